### hdl/lru_page_replacement_macros.svh
// Assertion macros used by the checker file of the page-frame manager.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Concurrent check, switched off while reset is high.
`define LRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Concurrent check that also holds during reset.
`define LRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### hdl/lrp_pkg.sv
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared word types and fixed field widths of the LRU page-frame manager.
// ----------------------------------------------------------------------------
package lrp_pkg;

  localparam int PAGE_W  = 16;
  localparam int FIDX_W  = 3;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 4;

  localparam logic [CFG_W-1:0]   FRAMES_RESET = 4'd8;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

  // One page reference.
  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic              last_reference;
  } req_word_t;

  // One reference result.
  typedef struct packed {
    logic               hit;
    logic [FIDX_W-1:0]  frame_index;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] fault_count;
    logic               last_of_run;
  } rsp_word_t;

  // Lookup outcome from the frame store.
  typedef struct packed {
    logic              hit;
    logic [FIDX_W-1:0] frame_index;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
  } lookup_t;

endpackage

### hdl/lrp_frame_store.sv
// ----------------------------------------------------------------------------
// lrp_frame_store
// Frame tags, valid bits and recency ranks, with the parallel tag compare,
// empty-frame and victim selection, and rank update for one reference.
// ----------------------------------------------------------------------------
module lrp_frame_store #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [lrp_pkg::PAGE_W-1:0] page,
  input  logic                      last,
  input  logic [lrp_pkg::CFG_W-1:0] frames_in_use,
  output lrp_pkg::lookup_t          lookup
);

  localparam int SB = (PAGE_BITS < lrp_pkg::PAGE_W) ? PAGE_BITS : lrp_pkg::PAGE_W;
  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RW = FW;
  localparam int NW = $clog2(MAX_FRAMES + 1);
  localparam logic [RW-1:0] RANK_MAX   = RW'(MAX_FRAMES - 1);
  localparam logic [RW:0]   LIMIT_MISS = (RW + 1)'(MAX_FRAMES);

  logic [SB-1:0]         tag   [MAX_FRAMES];
  logic [RW-1:0]         rank  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid;

  logic [SB-1:0]         pg;
  logic [NW-1:0]         n_act;
  logic [MAX_FRAMES-1:0] act;
  logic [MAX_FRAMES-1:0] hit_vec;
  logic [MAX_FRAMES-1:0] empty_vec;
  logic [FW-1:0]         hit_f;
  logic [FW-1:0]         empty_f;
  logic [FW-1:0]         vic_f;
  logic [RW-1:0]         best;
  logic [FW-1:0]         frame;
  logic                  is_hit;
  logic                  any_empty;
  logic [RW:0]           limit;
  logic [RW-1:0]         rank_next [MAX_FRAMES];
  logic [FW+2:0]         frame_ext;

  assign pg = page[SB-1:0];

  // Effective frame count: zero reads as one, clipped at the store depth.
  always_comb begin
    if (frames_in_use == '0) begin
      n_act = NW'(1);
    end else if (32'(frames_in_use) > MAX_FRAMES) begin
      n_act = NW'(MAX_FRAMES);
    end else begin
      n_act = NW'(frames_in_use);
    end
  end

  // Per-frame compare
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      act[i]       = 32'(i) < 32'(n_act);
      hit_vec[i]   = act[i] && valid[i] && (tag[i] == pg);
      empty_vec[i] = act[i] && !valid[i];
    end
  end

  // Lowest-index hit and empty frame
  always_comb begin
    hit_f   = '0;
    empty_f = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_f = FW'(i);
      end
      if (empty_vec[i]) begin
        empty_f = FW'(i);
      end
    end
  end

  assign is_hit    = |hit_vec;
  assign any_empty = |empty_vec;

  // Victim: highest rank among frames in use, lowest index on ties
  always_comb begin
    best  = '0;
    vic_f = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (act[i] && (rank[i] > best)) begin
        best  = rank[i];
        vic_f = FW'(i);
      end
    end
  end

  always_comb begin
    if (is_hit) begin
      frame = hit_f;
    end else if (any_empty) begin
      frame = empty_f;
    end else begin
      frame = vic_f;
    end
  end

  // Aging limit: on a hit only frames more recent than the hit frame age
  assign limit = is_hit ? {1'b0, rank[hit_f]} : LIMIT_MISS;

  // Rank update
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      rank_next[i] = rank[i];
      if (FW'(i) == frame) begin
        rank_next[i] = '0;
      end else if (act[i] && valid[i] && ({1'b0, rank[i]} < limit) &&
                   (rank[i] < RANK_MAX)) begin
        rank_next[i] = rank[i] + 1'b1;
      end
    end
  end

  // Result fields
  assign frame_ext            = (FW + 3)'(frame);
  assign lookup.hit           = is_hit;
  assign lookup.frame_index   = frame_ext[2:0];
  assign lookup.evicted_valid = !is_hit && !any_empty;
  assign lookup.evicted_page  = (!is_hit && !any_empty) ?
                                lrp_pkg::PAGE_W'(tag[vic_f]) : '0;

  // Valid bits and ranks; end of run empties the store
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank[i] <= '0;
      end
    end else if (go) begin
      if (last) begin
        valid <= '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
          rank[i] <= '0;
        end
      end else begin
        valid[frame] <= 1'b1;
        for (int i = 0; i < MAX_FRAMES; i++) begin
          rank[i] <= rank_next[i];
        end
      end
    end
  end

  // Tags; contents of empty frames are never looked at
  always_ff @(posedge clk) begin
    if (go && !is_hit) begin
      tag[frame] <= pg;
    end
  end

endmodule

### hdl/lru_page_replacement.sv
// Path: input register, then result register driving rsp_word; one reference per
// cycle while rsp_stall does not hold the result register; lookup, victim choice
// and rank update are one pass from the input register to the result register.
// Reset: all frames empty, ranks and hit/fault counts zero, frame count 8.
// No clearing pass; the block accepts references the cycle after reset.
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page-frame manager with saturating hit/fault counts.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  lrp_pkg::req_word_t        req_word,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output lrp_pkg::rsp_word_t        rsp_word,
  input  logic                      cfg_we,
  input  logic [lrp_pkg::CFG_W-1:0] cfg_wdata
);

  logic [lrp_pkg::CFG_W-1:0]   frames_cfg;
  logic                        s1_valid;
  lrp_pkg::req_word_t          s1_word;
  logic                        advance;
  lrp_pkg::lookup_t            lookup;
  logic [lrp_pkg::COUNT_W-1:0] hits;
  logic [lrp_pkg::COUNT_W-1:0] faults;
  logic [lrp_pkg::COUNT_W-1:0] hits_next;
  logic [lrp_pkg::COUNT_W-1:0] faults_next;

  // Frame count register
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_cfg <= lrp_pkg::FRAMES_RESET;
    end else if (cfg_we) begin
      frames_cfg <= cfg_wdata;
    end
  end

  // Handshake: the input stage moves on when the result register is free
  assign advance   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_word <= req_word;
    end
  end

  lrp_frame_store #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_store (
    .clk           (clk),
    .rst           (rst),
    .go            (advance),
    .page          (s1_word.page_number),
    .last          (s1_word.last_reference),
    .frames_in_use (frames_cfg),
    .lookup        (lookup)
  );

  // Saturating counts
  always_comb begin
    hits_next   = hits;
    faults_next = faults;
    if (lookup.hit) begin
      if (hits != lrp_pkg::COUNT_MAX) begin
        hits_next = hits + 1'b1;
      end
    end else begin
      if (faults != lrp_pkg::COUNT_MAX) begin
        faults_next = faults + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits   <= '0;
      faults <= '0;
    end else if (advance) begin
      if (s1_word.last_reference) begin
        hits   <= '0;
        faults <= '0;
      end else begin
        hits   <= hits_next;
        faults <= faults_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_word.hit           <= lookup.hit;
      rsp_word.frame_index   <= lookup.frame_index;
      rsp_word.evicted_valid <= lookup.evicted_valid;
      rsp_word.evicted_page  <= lookup.evicted_page;
      rsp_word.hit_count     <= hits_next;
      rsp_word.fault_count   <= faults_next;
      rsp_word.last_of_run   <= s1_word.last_reference;
    end
  end

endmodule

### hdl/lrp_checker.sv
// ----------------------------------------------------------------------------
// lrp_checker
// Port-level checks of the LRU page-frame manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_macros.svh"

module lrp_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input lrp_pkg::rsp_word_t rsp_word
);

  // Nothing pending right after reset
  `LRP_ASSERT_ALWAYS(a_reset_idle, rst |=> !rsp_valid && !req_stall, "busy after reset")

  // A stalled result word holds
  `LRP_ASSERT(a_rsp_hold,
              rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word),
              "result changed while stalled")

  // Input is held back only by a full, stalled result register
  `LRP_ASSERT(a_stall_cause, req_stall |-> rsp_valid && rsp_stall,
              "input stalled with free output")

  // A hit never evicts
  `LRP_ASSERT(a_hit_no_evict,
              rsp_valid && rsp_word.hit |->
                !rsp_word.evicted_valid && (rsp_word.evicted_page == '0),
              "eviction reported on a hit")

  // Within a run the counts never go down
  `LRP_ASSERT(a_count_mono,
              (rsp_valid && !rsp_stall && !rsp_word.last_of_run) ##1 rsp_valid |->
                (rsp_word.hit_count >= $past(rsp_word.hit_count)) &&
                (rsp_word.fault_count >= $past(rsp_word.fault_count)),
              "count decreased within a run")

endmodule

bind lru_page_replacement lrp_checker u_lrp_checker (.*);
